FILE: src/bitmap_store_with_undo_journal_unit_macros.svh
// Assertion helpers shared by the files that carry concurrent checks.
// Every check is clocked on i_clk and is off while i_rst_n is low.
`ifndef BITMAP_STORE_WITH_UNDO_JOURNAL_UNIT_MACROS_SVH
`define BITMAP_STORE_WITH_UNDO_JOURNAL_UNIT_MACROS_SVH

// A condition that must hold at every clock edge.
`define BSUJ_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold at the edge after its cause.
`define BSUJ_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bsuj_pkg.sv
package bsuj_pkg;

    localparam int MAX_WIDTH     = 512;
    localparam int MAX_HEIGHT    = 512;
    localparam int JOURNAL_DEPTH = 4096;

    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int PIX_AW    = XW + YW;
    localparam int PIX_DEPTH = 1 << PIX_AW;
    localparam int JAW       = $clog2(JOURNAL_DEPTH);
    localparam int CNTW      = $clog2(JOURNAL_DEPTH + 1);

    // Fixed field widths of the ports.
    localparam int OPW   = 3;
    localparam int CRDW  = 11;
    localparam int CFGW  = 10;
    localparam int LVLW  = 13;
    localparam int EFFW  = 11;
    localparam int CIDXW = 1;

    localparam logic [OPW-1:0] OP_WRITE = 3'd0;
    localparam logic [OPW-1:0] OP_READ  = 3'd1;
    localparam logic [OPW-1:0] OP_MARK  = 3'd2;
    localparam logic [OPW-1:0] OP_UNDO  = 3'd3;
    localparam logic [OPW-1:0] OP_CLEAR = 3'd4;

    localparam logic [CIDXW-1:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [CIDXW-1:0] REG_CANVAS_HEIGHT = 1'd1;

    typedef struct packed {
        logic          mark;
        logic          old_bit;
        logic [XW-1:0] jx;
        logic [YW-1:0] jy;
    } t_jentry;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PIX,
        S_UNDO_RD,
        S_UNDO_WB,
        S_CLR_SCAN,
        S_CLR_DRAIN,
        S_DONE
    } t_state;

endpackage

FILE: src/bsuj_cmd_if.sv
interface bsuj_cmd_if;
    logic                              valid;
    logic                              ready;
    logic        [bsuj_pkg::OPW-1:0]   op;
    logic signed [bsuj_pkg::CRDW-1:0]  x;
    logic signed [bsuj_pkg::CRDW-1:0]  y;
    logic                              value;

    modport source (output valid, op, x, y, value, input ready);
    modport sink   (input valid, op, x, y, value, output ready);
endinterface

FILE: src/bsuj_rsp_if.sv
interface bsuj_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        pixel_bit;
    logic                        entry_dropped;
    logic [bsuj_pkg::LVLW-1:0]   journal_level;

    modport source (output valid, pixel_bit, entry_dropped, journal_level, input ready);
    modport sink   (input valid, pixel_bit, entry_dropped, journal_level, output ready);
endinterface

FILE: src/bsuj_ram.sv
module bsuj_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/bitmap_store_with_undo_journal_unit.sv
// An in-range write or read reads the pixel on acceptance and then writes it or returns
// it; mark, unused ops, out-of-range accesses and a clear of an empty canvas answer on
// acceptance. Undo pops and writes back one entry at a time up to a mark or an empty journal;
// clear reads each pixel in range. One item at a time; a waiting result holds off the next
// one. Reset: synchronous, active low; a pass over PIX_DEPTH (262144) entries then zeroes the
// pixel RAM, one entry a cycle, while no transaction is accepted (config writes still taken).
`include "bitmap_store_with_undo_journal_unit_macros.svh"

module bitmap_store_with_undo_journal_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bsuj_pkg::CIDXW-1:0]       i_cfg_idx,
    input  logic [bsuj_pkg::CFGW-1:0]        i_cfg_data,
    bsuj_cmd_if.sink                         i_cmd,
    bsuj_rsp_if.source                       o_rsp
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    bsuj_pkg::t_state              r_state, n_state;
    logic [bsuj_pkg::PIX_AW-1:0]   r_init_addr;
    logic [bsuj_pkg::CFGW-1:0]     r_cfg_w, r_cfg_h;
    logic [bsuj_pkg::JAW-1:0]      r_top, n_top;
    logic [bsuj_pkg::CNTW-1:0]     r_count, n_count;
    logic                          r_drop;

    // Operand of a pending pixel access.
    logic                          r_is_wr;
    logic                          r_val;
    logic [bsuj_pkg::XW-1:0]       r_px;
    logic [bsuj_pkg::YW-1:0]       r_py;

    // Clear scan position and the pixel whose read data arrives this cycle.
    logic [bsuj_pkg::XW-1:0]       r_cx, r_pend_x;
    logic [bsuj_pkg::YW-1:0]       r_cy, r_pend_y;
    logic                          r_pend_v;

    // Output register.
    logic                          r_ovalid, r_obit, r_odrop;
    logic [bsuj_pkg::LVLW-1:0]     r_olevel;

    // ------------------------------------------------------------------
    // Combinational control
    // ------------------------------------------------------------------
    logic [bsuj_pkg::EFFW-1:0]     eff_w, eff_h;
    logic                          cmd_fire, cmd_rdy, out_free, cmd_in_rng, area_empty;
    logic                          clr_x_last, clr_y_last, pend_hit, undo_in_rng;

    logic                          pix_we, pix_wdata, pix_re, pix_rdata;
    logic [bsuj_pkg::PIX_AW-1:0]   pix_waddr, pix_raddr;

    logic                          push_en, pop_en, push_drop, jrnl_full;
    bsuj_pkg::t_jentry             push_data, j_rdata;
    logic [bsuj_pkg::JAW-1:0]      top_prev, top_next;

    logic                          emit, emit_bit;
    logic                          cnt_in_bound, mark_grow;

    // Register values beyond the store clamp to the store size.
    assign eff_w = (bsuj_pkg::EFFW'(r_cfg_w) > bsuj_pkg::EFFW'(bsuj_pkg::MAX_WIDTH))
                 ? bsuj_pkg::EFFW'(bsuj_pkg::MAX_WIDTH) : bsuj_pkg::EFFW'(r_cfg_w);
    assign eff_h = (bsuj_pkg::EFFW'(r_cfg_h) > bsuj_pkg::EFFW'(bsuj_pkg::MAX_HEIGHT))
                 ? bsuj_pkg::EFFW'(bsuj_pkg::MAX_HEIGHT) : bsuj_pkg::EFFW'(r_cfg_h);
    assign area_empty = (eff_w == '0) || (eff_h == '0);

    assign cmd_fire = i_cmd.valid && cmd_rdy;
    assign out_free = !r_ovalid || o_rsp.ready;
    assign i_cmd.ready = cmd_rdy;

    // A negative coordinate has its sign bit set; the rest is compared unsigned.
    assign cmd_in_rng = !i_cmd.x[bsuj_pkg::CRDW-1] && !i_cmd.y[bsuj_pkg::CRDW-1]
                     && ({1'b0, i_cmd.x[bsuj_pkg::CRDW-2:0]} < eff_w)
                     && ({1'b0, i_cmd.y[bsuj_pkg::CRDW-2:0]} < eff_h);

    assign undo_in_rng = (bsuj_pkg::EFFW'(j_rdata.jx) < eff_w)
                      && (bsuj_pkg::EFFW'(j_rdata.jy) < eff_h);

    assign clr_x_last = (bsuj_pkg::EFFW'(r_cx) + bsuj_pkg::EFFW'(1)) == eff_w;
    assign clr_y_last = (bsuj_pkg::EFFW'(r_cy) + bsuj_pkg::EFFW'(1)) == eff_h;
    assign pend_hit   = r_pend_v && pix_rdata;

    // Journal ring pointer arithmetic.
    assign top_prev = (r_top == '0) ? bsuj_pkg::JAW'(bsuj_pkg::JOURNAL_DEPTH - 1)
                                    : r_top - 1'b1;
    assign top_next = (r_top == bsuj_pkg::JAW'(bsuj_pkg::JOURNAL_DEPTH - 1)) ? '0
                                    : r_top + 1'b1;

    // A push into a full journal overwrites the oldest entry and leaves the count alone.
    assign jrnl_full = (r_count == bsuj_pkg::CNTW'(bsuj_pkg::JOURNAL_DEPTH));
    assign push_drop = push_en && jrnl_full;

    always_comb begin
        n_top   = r_top;
        n_count = r_count;
        if (push_en) begin
            n_top = top_next;
            if (!push_drop) begin
                n_count = r_count + 1'b1;
            end
        end else if (pop_en) begin
            n_top   = top_prev;
            n_count = r_count - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // State machine: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsuj_pkg::S_INIT: begin
                if (r_init_addr == '1) begin
                    n_state = bsuj_pkg::S_IDLE;
                end
            end
            bsuj_pkg::S_IDLE: begin
                if (cmd_fire) begin
                    case (i_cmd.op)
                        bsuj_pkg::OP_WRITE, bsuj_pkg::OP_READ: begin
                            if (cmd_in_rng) begin
                                n_state = bsuj_pkg::S_PIX;
                            end
                        end
                        bsuj_pkg::OP_UNDO: n_state = bsuj_pkg::S_UNDO_RD;
                        bsuj_pkg::OP_CLEAR: begin
                            if (!area_empty) begin
                                n_state = bsuj_pkg::S_CLR_SCAN;
                            end
                        end
                        default: n_state = bsuj_pkg::S_IDLE;
                    endcase
                end
            end
            bsuj_pkg::S_PIX: begin
                if (out_free) begin
                    n_state = bsuj_pkg::S_IDLE;
                end
            end
            bsuj_pkg::S_UNDO_RD: begin
                n_state = (r_count == '0) ? bsuj_pkg::S_DONE : bsuj_pkg::S_UNDO_WB;
            end
            bsuj_pkg::S_UNDO_WB: begin
                n_state = j_rdata.mark ? bsuj_pkg::S_DONE : bsuj_pkg::S_UNDO_RD;
            end
            bsuj_pkg::S_CLR_SCAN: begin
                if (clr_x_last && clr_y_last) begin
                    n_state = bsuj_pkg::S_CLR_DRAIN;
                end
            end
            bsuj_pkg::S_CLR_DRAIN: n_state = bsuj_pkg::S_DONE;
            bsuj_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = bsuj_pkg::S_IDLE;
                end
            end
            default: n_state = bsuj_pkg::S_INIT;
        endcase
    end

    // ------------------------------------------------------------------
    // State machine: memory controls, journal push/pop and result
    // ------------------------------------------------------------------
    always_comb begin
        cmd_rdy   = 1'b0;
        pix_we    = 1'b0;
        pix_waddr = '0;
        pix_wdata = 1'b0;
        pix_re    = 1'b0;
        pix_raddr = '0;
        push_en   = 1'b0;
        push_data = '0;
        pop_en    = 1'b0;
        emit      = 1'b0;
        emit_bit  = 1'b0;
        case (r_state)
            bsuj_pkg::S_INIT: begin
                pix_we    = 1'b1;
                pix_waddr = r_init_addr;
            end
            bsuj_pkg::S_IDLE: begin
                cmd_rdy = out_free;
                if (cmd_fire) begin
                    case (i_cmd.op)
                        bsuj_pkg::OP_WRITE, bsuj_pkg::OP_READ: begin
                            if (cmd_in_rng) begin
                                pix_re    = 1'b1;
                                pix_raddr = {i_cmd.y[bsuj_pkg::YW-1:0],
                                             i_cmd.x[bsuj_pkg::XW-1:0]};
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        bsuj_pkg::OP_MARK: begin
                            push_en        = 1'b1;
                            push_data.mark = 1'b1;
                            emit           = 1'b1;
                        end
                        bsuj_pkg::OP_UNDO: emit = 1'b0;
                        bsuj_pkg::OP_CLEAR: begin
                            push_en        = 1'b1;
                            push_data.mark = 1'b1;
                            emit           = area_empty;
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            bsuj_pkg::S_PIX: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_is_wr) begin
                        push_en           = 1'b1;
                        push_data.old_bit = pix_rdata;
                        push_data.jx      = r_px;
                        push_data.jy      = r_py;
                        pix_we            = 1'b1;
                        pix_waddr         = {r_py, r_px};
                        pix_wdata         = r_val;
                    end else begin
                        emit_bit = pix_rdata;
                    end
                end
            end
            bsuj_pkg::S_UNDO_RD: begin
                pop_en = (r_count != '0);
            end
            bsuj_pkg::S_UNDO_WB: begin
                // A record that lies outside a since-shrunk canvas is dropped silently.
                if (!j_rdata.mark && undo_in_rng) begin
                    pix_we    = 1'b1;
                    pix_waddr = {j_rdata.jy, j_rdata.jx};
                    pix_wdata = j_rdata.old_bit;
                end
            end
            bsuj_pkg::S_CLR_SCAN, bsuj_pkg::S_CLR_DRAIN: begin
                // Read the next pixel while the previous one is journaled and zeroed.
                pix_re    = (r_state == bsuj_pkg::S_CLR_SCAN);
                pix_raddr = {r_cy, r_cx};
                if (pend_hit) begin
                    push_en           = 1'b1;
                    push_data.old_bit = 1'b1;
                    push_data.jx      = r_pend_x;
                    push_data.jy      = r_pend_y;
                    pix_we            = 1'b1;
                    pix_waddr         = {r_pend_y, r_pend_x};
                end
            end
            bsuj_pkg::S_DONE: begin
                emit = out_free;
            end
            default: emit = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    bsuj_ram #(
        .WIDTH (1),
        .DEPTH (bsuj_pkg::PIX_DEPTH)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_re    (pix_re),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    bsuj_ram #(
        .WIDTH ($bits(bsuj_pkg::t_jentry)),
        .DEPTH (bsuj_pkg::JOURNAL_DEPTH)
    ) u_jrnl_ram (
        .i_clk   (i_clk),
        .i_we    (push_en),
        .i_waddr (r_top),
        .i_wdata (push_data),
        .i_re    (pop_en),
        .i_raddr (top_prev),
        .o_rdata (j_rdata)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsuj_pkg::S_INIT;
            r_init_addr <= '0;
            r_cfg_w     <= bsuj_pkg::CFGW'(bsuj_pkg::MAX_WIDTH);
            r_cfg_h     <= bsuj_pkg::CFGW'(bsuj_pkg::MAX_HEIGHT);
            r_top       <= '0;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_pend_v    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_count <= n_count;
            if (r_state == bsuj_pkg::S_INIT) begin
                r_init_addr <= r_init_addr + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bsuj_pkg::REG_CANVAS_WIDTH:  r_cfg_w <= i_cfg_data;
                    bsuj_pkg::REG_CANVAS_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: r_cfg_w <= r_cfg_w;
                endcase
            end
            // The drop flag collects every overflow within one transaction.
            if (cmd_fire) begin
                r_drop <= push_drop;
            end else if (push_drop) begin
                r_drop <= 1'b1;
            end
            if (cmd_fire) begin
                r_pend_v <= 1'b0;
            end else if (r_state == bsuj_pkg::S_CLR_SCAN) begin
                r_pend_v <= 1'b1;
            end else if (r_state == bsuj_pkg::S_CLR_DRAIN) begin
                r_pend_v <= 1'b0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_is_wr <= (i_cmd.op == bsuj_pkg::OP_WRITE);
            r_val   <= i_cmd.value;
            r_px    <= i_cmd.x[bsuj_pkg::XW-1:0];
            r_py    <= i_cmd.y[bsuj_pkg::YW-1:0];
            r_cx    <= '0;
            r_cy    <= '0;
        end else if (r_state == bsuj_pkg::S_CLR_SCAN) begin
            r_pend_x <= r_cx;
            r_pend_y <= r_cy;
            if (clr_x_last) begin
                r_cx <= '0;
                r_cy <= r_cy + 1'b1;
            end else begin
                r_cx <= r_cx + 1'b1;
            end
        end
        if (emit) begin
            r_obit   <= emit_bit;
            // A result sent in the accepting cycle must not see the previous item's flag.
            r_odrop  <= (r_drop && !cmd_fire) || push_drop;
            r_olevel <= bsuj_pkg::LVLW'(n_count);
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.pixel_bit     = r_obit;
    assign o_rsp.entry_dropped = r_odrop;
    assign o_rsp.journal_level = r_olevel;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    assign cnt_in_bound = (r_count <= bsuj_pkg::CNTW'(bsuj_pkg::JOURNAL_DEPTH));
    assign mark_grow    = cmd_fire && (i_cmd.op == bsuj_pkg::OP_MARK) && !jrnl_full;

    `BSUJ_ALWAYS(a_count_bound, cnt_in_bound, "journal count beyond depth")
    `BSUJ_ALWAYS(a_push_pop_excl, !(push_en && pop_en), "journal push and pop in one cycle")
    `BSUJ_ALWAYS(a_emit_room, !emit || out_free, "result produced while output register busy")
    `BSUJ_NEXT(a_mark_push, mark_grow, r_count == $past(r_count) + 1'b1, "mark did not push")

endmodule
